// ----- rtl/nft_pkg.sv -----
// ----------------------------------------------------------------------------
// nft_pkg: shared constants and types for the noise floor tracker
// Register indexes, counter widths, reset values and the detector control.
// ----------------------------------------------------------------------------
package nft_pkg;

  localparam int SMOOTH_W  = 16;  // smoothing factor, unsigned Q0.16
  localparam int WIN_W     = 10;  // window length register
  localparam int HOLD_W    = 12;  // hold counters, bounds up to 3 * window
  localparam int FRAMES_W  = 11;  // change detector frame counter
  localparam int COUNT_W   = 11;  // change detector quiet frame count
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0]  CHANGE_LIMIT = 11'd9;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 11'd2047;
  localparam logic [WIN_W-1:0]    WINDOW_RST   = 10'd100;
  localparam logic [SMOOTH_W-1:0] SMOOTH_RST   = 16'd13107;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_NOISE = 2'd0,
    CFG_MIN_NOISE = 2'd1,
    CFG_WINDOW    = 2'd2,
    CFG_SMOOTHING = 2'd3
  } cfg_idx_e;

  // Sequencer commands to the noise change detector.
  typedef struct packed {
    logic init;
    logic step;
  } chg_ctrl_t;

endpackage

// ----- rtl/nft_track_step.sv -----
// ----------------------------------------------------------------------------
// nft_track_step: one running-minimum tracker update
// Held minimum, candidate and hold counter for one frame; shared by the
// fast and slow trackers.
// ----------------------------------------------------------------------------
module nft_track_step import nft_pkg::*; #(
  parameter int ENERGY_WIDTH = 32
) (
  input  logic [ENERGY_WIDTH-1:0] energy_i,
  input  logic [ENERGY_WIDTH-1:0] max_noise_i,
  input  logic [ENERGY_WIDTH-1:0] min_i,
  input  logic [ENERGY_WIDTH-1:0] cand_i,
  input  logic [HOLD_W-1:0]       hold_i,
  input  logic [HOLD_W-1:0]       half_i,
  input  logic [HOLD_W-1:0]       upper_i,
  output logic [ENERGY_WIDTH-1:0] min_o,
  output logic [ENERGY_WIDTH-1:0] cand_o,
  output logic [HOLD_W-1:0]       hold_o,
  output logic                    replaced_o,
  output logic [ENERGY_WIDTH-1:0] old_min_o
);

  logic                    below;
  logic                    expire;
  logic [HOLD_W-1:0]       hold1;
  logic [ENERGY_WIDTH-1:0] min1;
  logic [ENERGY_WIDTH-1:0] cand1;
  logic [ENERGY_WIDTH-1:0] cand2;

  always_comb begin
    below = energy_i < min_i;
    if (below) begin
      min1  = energy_i;
      hold1 = '0;
      cand1 = max_noise_i;
    end else begin
      min1  = min_i;
      hold1 = hold_i + HOLD_W'(1);
      cand1 = cand_i;
    end
    cand2  = ((hold1 > half_i) && (energy_i < cand1)) ? energy_i : cand1;
    // window expired: candidate takes over
    expire = hold1 > upper_i;
    min_o      = expire ? cand2 : min1;
    cand_o     = expire ? max_noise_i : cand2;
    hold_o     = expire ? half_i : hold1;
    replaced_o = below || expire;
    old_min_o  = expire ? min1 : min_i;
  end

endmodule

// ----- rtl/nft_smooth_unit.sv -----
// ----------------------------------------------------------------------------
// nft_smooth_unit: shared level smoothing multiplier
// level += (target - level) * smoothing >> 16, arithmetic shift.
// Registered steps: magnitude, product, apply. Operands held by the caller.
// ----------------------------------------------------------------------------
module nft_smooth_unit import nft_pkg::*; #(
  parameter int LEVEL_WIDTH = 48
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [LEVEL_WIDTH-1:0] target_i,
  input  logic [LEVEL_WIDTH-1:0] level_i,
  input  logic [SMOOTH_W-1:0]    smoothing_i,
  output logic                   done_o,
  output logic [LEVEL_WIDTH-1:0] level_o
);

  localparam int PW = LEVEL_WIDTH + SMOOTH_W;

  logic                   v1_q, v2_q, done_q;
  logic                   up_q;
  logic [LEVEL_WIDTH-1:0] mag_q;
  logic [PW-1:0]          prod_q;
  logic [LEVEL_WIDTH-1:0] res_q;
  logic [LEVEL_WIDTH-1:0] quot;
  logic [LEVEL_WIDTH:0]   dec;
  logic [LEVEL_WIDTH-1:0] res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  // downward steps round toward minus infinity: ceiling of the magnitude
  always_comb begin
    quot  = prod_q[PW-1:SMOOTH_W];
    dec   = {1'b0, quot} + (LEVEL_WIDTH + 1)'(|prod_q[SMOOTH_W-1:0]);
    res_d = up_q ? (level_i + quot) : (level_i - dec[LEVEL_WIDTH-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      up_q  <= target_i >= level_i;
      mag_q <= (target_i >= level_i) ? (target_i - level_i) : (level_i - target_i);
    end
    if (v1_q) begin
      prod_q <= {{SMOOTH_W{1'b0}}, mag_q} * {{LEVEL_WIDTH{1'b0}}, smoothing_i};
    end
    if (v2_q) begin
      res_q <= res_d;
    end
  end

  assign done_o  = done_q;
  assign level_o = res_q;

endmodule

// ----- rtl/nft_change_det.sv -----
// ----------------------------------------------------------------------------
// nft_change_det: noise change detector
// Arms on a 2x jump of the fast minimum, counts quiet frames, requests
// updates until the count limit, disarms after a window.
// ----------------------------------------------------------------------------
module nft_change_det import nft_pkg::*; #(
  parameter int ENERGY_WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  chg_ctrl_t               ctrl_i,
  input  logic [ENERGY_WIDTH-1:0] fast_min_i,
  input  logic [ENERGY_WIDTH-1:0] prev_min_i,
  input  logic [ENERGY_WIDTH-1:0] energy_i,
  input  logic [WIN_W-1:0]        window_i,
  output logic                    update_o
);

  logic                    active_q;
  logic [FRAMES_W-1:0]     frames_q;
  logic [COUNT_W-1:0]      count_q;
  logic                    update_q;

  logic                    jump;
  logic                    active1;
  logic [FRAMES_W-1:0]     frames1;
  logic [FRAMES_W-1:0]     frames2;
  logic [ENERGY_WIDTH+3:0] ten_min;
  logic                    quiet;
  logic [COUNT_W-1:0]      count1;
  logic                    upd1;
  logic                    expire;

  always_comb begin
    jump    = ({1'b0, fast_min_i} > {prev_min_i, 1'b0}) ||
              ({1'b0, prev_min_i} > {fast_min_i, 1'b0});
    active1 = active_q || jump;
    frames1 = (jump && !active_q) ? '0 : frames_q;
    ten_min = ({4'b0, fast_min_i} << 3) + ({4'b0, fast_min_i} << 1);
    quiet   = active1 && ({4'b0, energy_i} < ten_min);
    count1  = (quiet && (count_q != COUNT_MAX)) ? count_q + COUNT_W'(1) : count_q;
    upd1    = quiet && (count1 < CHANGE_LIMIT);
    frames2 = frames1 + FRAMES_W'(1);
    expire  = frames2 > {1'b0, window_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      frames_q <= '0;
      count_q  <= '0;
      update_q <= 1'b0;
    end else if (ctrl_i.init) begin
      active_q <= 1'b0;
      frames_q <= '0;
      count_q  <= '0;
      update_q <= 1'b0;
    end else if (ctrl_i.step) begin
      if (expire) begin
        active_q <= 1'b0;
        frames_q <= '0;
        count_q  <= '0;
        update_q <= 1'b0;
      end else begin
        active_q <= active1;
        frames_q <= frames2;
        count_q  <= count1;
        update_q <= upd1;
      end
    end
  end

  assign update_o = update_q;

endmodule

// ----- rtl/noise_floor_tracker_vad_top.sv -----
// ----------------------------------------------------------------------------
// noise_floor_tracker_vad_top: running-minimum noise floor and voice flag
// Fast and slow minimum trackers with smoothed levels, a noise change
// detector and a voice activity decision, one result per frame energy.
// ----------------------------------------------------------------------------
// Each input transaction carries one frame energy (unsigned Q16.16) and
// yields exactly one result transaction: the voice flag, the noise change
// update request and both smoothed noise levels (Q16.16, truncated). The
// block handles one frame at a time: it is not ready again until the
// sequencer has passed the fast level, and the slow one when the slow
// tracker is not gated off, through the shared smoothing multiplier. A
// finished result sits in an output register, so the next frame is
// accepted while the previous result waits. Any configuration write, to
// any index, re-initializes all tracker and detector state from the
// register values; the block is not ready while it does so, and the same
// happens once after reset.
// Configuration must only be written while no frame is in flight.
// ----------------------------------------------------------------------------
module noise_floor_tracker_vad_top import nft_pkg::*; #(
  parameter int ENERGY_WIDTH     = 32,
  parameter int LEVEL_EXTRA_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration write port
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ENERGY_WIDTH-1:0] cfg_data_i,
  // input channel
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ENERGY_WIDTH-1:0] energy_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    voice_active_o,
  output logic                    noise_change_update_o,
  output logic [ENERGY_WIDTH-1:0] fast_noise_level_o,
  output logic [ENERGY_WIDTH-1:0] slow_noise_level_o
);

  // levels are energies with extra fraction bits
  localparam int LW = ENERGY_WIDTH + LEVEL_EXTRA_BITS;

  typedef enum logic [3:0] {
    S_INIT,      // load tracker state from config
    S_IDLE,      // wait for a frame
    S_FTRACK,    // fast minimum / candidate / hold update
    S_FSMOOTH,   // start fast smoothing, step change detector
    S_FWAIT,     // wait for fast level
    S_GATE,      // slow tracker gate, energy floor clip
    S_STRACK,    // slow minimum update
    S_SSMOOTH,   // start slow smoothing
    S_SWAIT,     // wait for slow level
    S_VOICE      // voice decision, load output register
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  // configuration registers
  logic [ENERGY_WIDTH-1:0] max_noise_q;
  logic [ENERGY_WIDTH-1:0] min_noise_q;
  logic [WIN_W-1:0]        window_q;
  logic [SMOOTH_W-1:0]     smoothing_q;

  // tracker state
  logic [ENERGY_WIDTH-1:0] energy_q;
  logic [ENERGY_WIDTH-1:0] fast_min_q, fast_cand_q;
  logic [HOLD_W-1:0]       fast_hold_q;
  logic [LW-1:0]           fast_level_q;
  logic [ENERGY_WIDTH-1:0] slow_min_q, slow_cand_q;
  logic [HOLD_W-1:0]       slow_hold_q;
  logic [LW-1:0]           slow_level_q;
  logic [ENERGY_WIDTH-1:0] prev_min_q;

  // output register payload
  logic                    voice_q;
  logic                    change_q;
  logic [ENERGY_WIDTH-1:0] fast_out_q;
  logic [ENERGY_WIDTH-1:0] slow_out_q;

  logic                    out_free;
  logic                    in_accept;

  // shared tracker step
  logic                    trk_slow;
  logic [HOLD_W-1:0]       win3;
  logic [HOLD_W-1:0]       trk_half, trk_upper;
  logic [ENERGY_WIDTH-1:0] trk_min_d, trk_cand_d, trk_old_min_d;
  logic [HOLD_W-1:0]       trk_hold_d;
  logic                    trk_replaced;

  // shared smoothing unit
  logic                    sm_slow;
  logic                    sm_start;
  logic                    sm_done;
  logic [LW-1:0]           sm_level;

  // comparisons against scaled levels
  logic [LW-1:0]           energy_sh;
  logic [LW+3:0]           ten_fast, ten_slow;
  logic                    gate_d;
  logic                    voice_d;

  chg_ctrl_t               chg_ctrl;
  logic                    chg_update;

  assign out_free  = !out_valid_q || out_ready_i;
  // a config write in the same cycle wins; no frame is taken then
  assign in_ready_o = (state_q == S_IDLE) && !cfg_we_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_noise_q <= '1;
      min_noise_q <= ENERGY_WIDTH'(1);
      window_q    <= WINDOW_RST;
      smoothing_q <= SMOOTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_NOISE: max_noise_q <= cfg_data_i;
        CFG_MIN_NOISE: min_noise_q <= cfg_data_i;
        CFG_WINDOW:    window_q    <= cfg_data_i[WIN_W-1:0];
        CFG_SMOOTHING: smoothing_q <= cfg_data_i[SMOOTH_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Tracker step, shared: fast window = W, slow window = 2W.
  // Fast bounds: W/2 and 3W/2; slow bounds: W and 3W.
  // --------------------------------------------------------------------------
  assign trk_slow  = (state_q == S_STRACK);
  assign win3      = HOLD_W'({window_q, 1'b0}) + HOLD_W'(window_q);
  assign trk_half  = trk_slow ? HOLD_W'(window_q) : HOLD_W'(window_q >> 1);
  assign trk_upper = trk_slow ? win3 : (win3 >> 1);

  nft_track_step #(
    .ENERGY_WIDTH (ENERGY_WIDTH)
  ) u_track (
    .energy_i    (energy_q),
    .max_noise_i (max_noise_q),
    .min_i       (trk_slow ? slow_min_q  : fast_min_q),
    .cand_i      (trk_slow ? slow_cand_q : fast_cand_q),
    .hold_i      (trk_slow ? slow_hold_q : fast_hold_q),
    .half_i      (trk_half),
    .upper_i     (trk_upper),
    .min_o       (trk_min_d),
    .cand_o      (trk_cand_d),
    .hold_o      (trk_hold_d),
    .replaced_o  (trk_replaced),
    .old_min_o   (trk_old_min_d)
  );

  // --------------------------------------------------------------------------
  // Level smoothing, shared. Operands stay stable through the pass.
  // --------------------------------------------------------------------------
  assign sm_slow  = (state_q == S_SSMOOTH) || (state_q == S_SWAIT);
  assign sm_start = (state_q == S_FSMOOTH) || (state_q == S_SSMOOTH);

  nft_smooth_unit #(
    .LEVEL_WIDTH (LW)
  ) u_smooth (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (sm_start),
    .target_i    ({(sm_slow ? slow_min_q : fast_min_q), {LEVEL_EXTRA_BITS{1'b0}}}),
    .level_i     (sm_slow ? slow_level_q : fast_level_q),
    .smoothing_i (smoothing_q),
    .done_o      (sm_done),
    .level_o     (sm_level)
  );

  // --------------------------------------------------------------------------
  // Noise change detector, stepped once per frame after the fast update
  // --------------------------------------------------------------------------
  assign chg_ctrl.init = (state_q == S_INIT);
  assign chg_ctrl.step = (state_q == S_FSMOOTH);

  nft_change_det #(
    .ENERGY_WIDTH (ENERGY_WIDTH)
  ) u_change (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (chg_ctrl),
    .fast_min_i (fast_min_q),
    .prev_min_i (prev_min_q),
    .energy_i   (energy_q),
    .window_i   (window_q),
    .update_o   (chg_update)
  );

  // --------------------------------------------------------------------------
  // Gate and voice compares: energy << extra bits vs 10x / 20x level.
  // In S_VOICE the energy is the floored one if the slow tracker ran.
  // --------------------------------------------------------------------------
  assign energy_sh = {energy_q, {LEVEL_EXTRA_BITS{1'b0}}};
  assign ten_fast  = ({4'b0, fast_level_q} << 3) + ({4'b0, fast_level_q} << 1);
  assign ten_slow  = ({4'b0, slow_level_q} << 3) + ({4'b0, slow_level_q} << 1);
  assign gate_d    = {4'b0, energy_sh} < ten_fast;
  assign voice_d   = ({5'b0, energy_sh} > {ten_fast, 1'b0}) &&
                     ({5'b0, energy_sh} > {ten_slow, 1'b0});

  // --------------------------------------------------------------------------
  // Sequencer and output valid
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_VOICE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        state_q <= S_INIT;
      end else begin
        unique case (state_q)
          S_INIT:    state_q <= S_IDLE;
          S_IDLE:    if (in_accept) state_q <= S_FTRACK;
          S_FTRACK:  state_q <= S_FSMOOTH;
          S_FSMOOTH: state_q <= S_FWAIT;
          S_FWAIT:   if (sm_done) state_q <= S_GATE;
          S_GATE:    state_q <= gate_d ? S_STRACK : S_VOICE;
          S_STRACK:  state_q <= S_SSMOOTH;
          S_SSMOOTH: state_q <= S_SWAIT;
          S_SWAIT:   if (sm_done) state_q <= S_VOICE;
          S_VOICE:   if (out_free) state_q <= S_IDLE;
          default:   state_q <= S_INIT;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers; tracker state loaded in S_INIT before first use
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_INIT: begin
        fast_min_q   <= max_noise_q;
        fast_cand_q  <= max_noise_q;
        fast_hold_q  <= '0;
        fast_level_q <= {min_noise_q, {LEVEL_EXTRA_BITS{1'b0}}};
        slow_min_q   <= max_noise_q;
        slow_cand_q  <= max_noise_q;
        slow_hold_q  <= '0;
        slow_level_q <= {min_noise_q, {LEVEL_EXTRA_BITS{1'b0}}};
        prev_min_q   <= max_noise_q;
      end
      S_IDLE: begin
        if (in_accept) energy_q <= energy_i;
      end
      S_FTRACK: begin
        fast_min_q  <= trk_min_d;
        fast_cand_q <= trk_cand_d;
        fast_hold_q <= trk_hold_d;
        if (trk_replaced) prev_min_q <= trk_old_min_d;
      end
      S_FWAIT: begin
        if (sm_done) fast_level_q <= sm_level;
      end
      S_GATE: begin
        // slow tracker sees the energy raised to the floor
        if (gate_d && (energy_q < min_noise_q)) energy_q <= min_noise_q;
      end
      S_STRACK: begin
        slow_min_q  <= trk_min_d;
        slow_cand_q <= trk_cand_d;
        slow_hold_q <= trk_hold_d;
      end
      S_SWAIT: begin
        if (sm_done) slow_level_q <= sm_level;
      end
      S_VOICE: begin
        if (out_free) begin
          voice_q    <= voice_d;
          change_q   <= chg_update;
          fast_out_q <= fast_level_q[LW-1:LEVEL_EXTRA_BITS];
          slow_out_q <= slow_level_q[LW-1:LEVEL_EXTRA_BITS];
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o           = out_valid_q;
  assign voice_active_o        = voice_q;
  assign noise_change_update_o = change_q;
  assign fast_noise_level_o    = fast_out_q;
  assign slow_noise_level_o    = slow_out_q;

endmodule

// ----- rtl/nft_checker.sv -----
// ----------------------------------------------------------------------------
// nft_checker: port-level checks for the noise floor tracker
// Busy period after a transaction, config re-init, output hold on stall.
// ----------------------------------------------------------------------------
module nft_checker #(
  parameter int ENERGY_WIDTH = 32
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_we_i,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic                    voice_active_o,
  input logic                    noise_change_update_o,
  input logic [ENERGY_WIDTH-1:0] fast_noise_level_o,
  input logic [ENERGY_WIDTH-1:0] slow_noise_level_o
);

  // one frame at a time: ready stays low after an accepted frame
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o)
    else $error("ready again too soon after an input transaction");

  // a result never appears the cycle right after acceptance
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !$rose(out_valid_o))
    else $error("result appeared without processing time");

  // a config write re-initializes state, so no frame is taken next cycle
  a_cfg_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_o)
    else $error("input taken during re-initialization");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(voice_active_o) && $stable(noise_change_update_o) &&
       $stable(fast_noise_level_o) && $stable(slow_noise_level_o)))
    else $error("result changed while stalled");

endmodule

bind noise_floor_tracker_vad_top nft_checker #(
  .ENERGY_WIDTH (ENERGY_WIDTH)
) u_nft_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .cfg_we_i              (cfg_we_i),
  .in_valid_i            (in_valid_i),
  .in_ready_o            (in_ready_o),
  .out_valid_o           (out_valid_o),
  .out_ready_i           (out_ready_i),
  .voice_active_o        (voice_active_o),
  .noise_change_update_o (noise_change_update_o),
  .fast_noise_level_o    (fast_noise_level_o),
  .slow_noise_level_o    (slow_noise_level_o)
);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for noise_floor_tracker_vad_top
// Frame energies are sent through the input channel, and each result is
// checked field by field against an in-bench noise floor predictor. The run
// covers several register settings and random handshake pressure.
// ----------------------------------------------------------------------------
module tb;
  import nft_pkg::*;

  localparam int EW             = 32;    // energy width, Q16.16
  localparam int XB             = 16;    // extra fraction bits of the levels
  localparam int LW             = EW + XB;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES   = 40;    // quiet time after the last result

  // One running-minimum tracker: held minimum, candidate, hold count, level.
  typedef struct packed {
    logic [EW-1:0]     minimum;
    logic [EW-1:0]     candidate;
    logic [HOLD_W-1:0] hold;
    logic [LW-1:0]     level;
  } floor_trk_t;

  // What one frame should produce on the result channel.
  typedef struct packed {
    logic          voice;
    logic          update;
    logic [EW-1:0] fast_lvl;
    logic [EW-1:0] slow_lvl;
  } frame_result_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // --------------------------------------------------------------------------
  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          cfg_we_i    = 1'b0;
  cfg_idx_e      cfg_idx_i   = CFG_MAX_NOISE;
  logic [EW-1:0] cfg_data_i  = '0;
  logic          in_valid_i  = 1'b0;
  logic [EW-1:0] energy_i    = '0;
  logic          out_ready_i = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  logic          voice_active_o;
  logic          noise_change_update_o;
  logic [EW-1:0] fast_noise_level_o;
  logic [EW-1:0] slow_noise_level_o;

  noise_floor_tracker_vad_top #(
    .ENERGY_WIDTH    (EW),
    .LEVEL_EXTRA_BITS(XB)
  ) u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .energy_i             (energy_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .voice_active_o       (voice_active_o),
    .noise_change_update_o(noise_change_update_o),
    .fast_noise_level_o   (fast_noise_level_o),
    .slow_noise_level_o   (slow_noise_level_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench bookkeeping
  // --------------------------------------------------------------------------
  logic [EW-1:0] frame_q[$];       // energies waiting for the driver
  frame_result_t result_q[$];      // predicted results, oldest first
  int            frames_open  = 0; // queued frames whose result is not back
  int            err_cnt      = 0;
  int            quiet_cycles = 0;
  int            send_idle_pct = 0; // chance per cycle that the sender holds off
  int            recv_idle_pct = 0; // chance per cycle that the receiver stalls
  int            random_frames = 0;

  // --------------------------------------------------------------------------
  // Noise floor predictor: register copies and tracker/detector state
  // --------------------------------------------------------------------------
  logic [EW-1:0]       max_noise;
  logic [EW-1:0]       min_noise;
  logic [WIN_W-1:0]    window;
  logic [SMOOTH_W-1:0] smooth;
  floor_trk_t          fast_trk;
  floor_trk_t          slow_trk;
  logic [EW-1:0]       prev_min;
  logic                chg_active;
  logic                chg_update;
  int unsigned         chg_frames;
  int unsigned         chg_count;

  function automatic floor_trk_t fresh_tracker();
    floor_trk_t t;
    t.minimum   = max_noise;
    t.candidate = max_noise;
    t.hold      = '0;
    t.level     = LW'(64'(min_noise) << XB);
    return t;
  endfunction

  // Same effect as a reset or any register write: state restarts from the
  // current register values.
  function automatic void restart_floor();
    fast_trk   = fresh_tracker();
    slow_trk   = fresh_tracker();
    prev_min   = max_noise;
    chg_active = 1'b0;
    chg_update = 1'b0;
    chg_frames = 0;
    chg_count  = 0;
  endfunction

  // level moves toward minimum by smooth/2^16 of the gap. The product is
  // shifted arithmetically, so a falling level rounds its step up.
  function automatic logic [LW-1:0] settle_level(input logic [LW-1:0] level,
                                                  input logic [EW-1:0] minimum);
    logic [63:0] target;
    logic [63:0] gap;
    logic [63:0] prod;
    logic [63:0] nxt;
    target = 64'(minimum) << XB;
    if (target >= 64'(level)) begin
      gap  = target - 64'(level);
      prod = gap * 64'(smooth);
      nxt  = 64'(level) + (prod >> SMOOTH_W);
    end else begin
      gap  = 64'(level) - target;
      prod = gap * 64'(smooth);
      nxt  = 64'(level) - ((prod >> SMOOTH_W) + ((prod[SMOOTH_W-1:0] != '0) ? 64'd1 : 64'd0));
    end
    return nxt[LW-1:0];
  endfunction

  // One step of a running-minimum tracker over a window of w frames.
  // Returns 1 when the held minimum was replaced; old_min gets the old one.
  function automatic logic track_floor(input floor_trk_t cur, input logic [EW-1:0] e,
                                       input int unsigned w, output floor_trk_t nxt,
                                       output logic [EW-1:0] old_min);
    int unsigned half;
    int unsigned upper;
    logic        replaced;
    half     = w >> 1;
    upper    = (3 * w) >> 1;
    replaced = 1'b0;
    nxt      = cur;
    old_min  = '0;
    if (e < nxt.minimum) begin
      old_min       = nxt.minimum;
      replaced      = 1'b1;
      nxt.minimum   = e;
      nxt.hold      = '0;
      nxt.candidate = max_noise;
    end else begin
      nxt.hold = nxt.hold + 1'b1;
    end
    if (nxt.hold > half && e < nxt.candidate) nxt.candidate = e;
    // hold ran past 1.5 windows: the candidate becomes the minimum
    if (nxt.hold > upper) begin
      old_min       = nxt.minimum;
      replaced      = 1'b1;
      nxt.minimum   = nxt.candidate;
      nxt.candidate = max_noise;
      nxt.hold      = HOLD_W'(half);
    end
    nxt.level = settle_level(nxt.level, nxt.minimum);
    return replaced;
  endfunction

  // Advances the predictor by one frame and returns the result it implies.
  function automatic frame_result_t predict_frame(input logic [EW-1:0] energy);
    logic [EW-1:0] e;
    logic [EW-1:0] old_min;
    logic [63:0]   fast_min;
    logic [63:0]   fast_lvl;
    logic [63:0]   slow_lvl;
    logic [63:0]   e_q;
    logic          replaced;
    floor_trk_t    upd;
    frame_result_t r;
    e        = energy;
    replaced = track_floor(fast_trk, e, window, upd, old_min);
    fast_trk = upd;
    if (replaced) prev_min = old_min;

    // noise change detector: arm on a 2x move of the fast minimum
    fast_min = 64'(fast_trk.minimum);
    if ((fast_min > 2 * 64'(prev_min) || 64'(prev_min) > 2 * fast_min) && !chg_active) begin
      chg_active = 1'b1;
      chg_frames = 0;
    end
    if (chg_active && 64'(e) < 64'd10 * fast_min) begin
      if (chg_count < COUNT_MAX) chg_count++;
      chg_update = 1'b1;
    end else begin
      chg_update = 1'b0;
    end
    if (chg_count >= CHANGE_LIMIT) chg_update = 1'b0;
    chg_frames++;
    if (chg_frames > window) begin
      chg_count  = 0;
      chg_active = 1'b0;
      chg_frames = 0;
      chg_update = 1'b0;
    end

    // slow tracker only sees frames below 10x the fast level; the energy is
    // floored there, and the floored value also feeds the voice decision
    fast_lvl = 64'(fast_trk.level);
    if ((64'(e) << XB) < 64'd10 * fast_lvl) begin
      if (e < min_noise) e = min_noise;
      void'(track_floor(slow_trk, e, 2 * window, upd, old_min));
      slow_trk = upd;
    end
    slow_lvl = 64'(slow_trk.level);

    e_q        = 64'(e) << XB;
    r.voice    = (e_q > 64'd20 * fast_lvl) && (e_q > 64'd20 * slow_lvl);
    r.update   = chg_update;
    r.fast_lvl = fast_trk.level[LW-1:XB];
    r.slow_lvl = slow_trk.level[LW-1:XB];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: feeds frame_q into the input channel. Valid is computed
  // once per edge and assigned once, so back-to-back transactions keep it high.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : frame_driver
    logic          nxt_valid;
    logic [EW-1:0] nxt_energy;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      nxt_valid  = in_valid_i;
      nxt_energy = energy_i;
      if (in_valid_i && in_ready_o) begin
        // accepted: predict now, the state matches the DUT's at this point
        result_q.push_back(predict_frame(energy_i));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_energy = frame_q.pop_front();
        nxt_valid  = 1'b1;
      end
      in_valid_i <= nxt_valid;
      energy_i   <= nxt_energy;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: checks each result transaction against the oldest
  // prediction, and drives ready with random stalls.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    err_cnt++;
    $display("%0t %s: expected %h, actual %h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : result_monitor
    frame_result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          note_mismatch("result with no frame pending", '0,
                        {fast_noise_level_o, slow_noise_level_o});
        end else begin
          want = result_q.pop_front();
          frames_open--;
          if (voice_active_o !== want.voice)
            note_mismatch("voice_active", want.voice, voice_active_o);
          if (noise_change_update_o !== want.update)
            note_mismatch("noise_change_update", want.update, noise_change_update_o);
          if (fast_noise_level_o !== want.fast_lvl)
            note_mismatch("fast_noise_level", want.fast_lvl, fast_noise_level_o);
          if (slow_noise_level_o !== want.slow_lvl)
            note_mismatch("slow_noise_level", want.slow_lvl, slow_noise_level_o);
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a hang shows up as a long stretch with no transaction at all
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("noise_floor_tracker_vad_top regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_frame(input logic [EW-1:0] e);
    frame_q.push_back(e);
    frames_open++;
  endtask

  // Block until every queued frame has come back as a result.
  task automatic wait_idle();
    @(posedge clk_i);
    while (frames_open != 0) @(posedge clk_i);
  endtask

  // Register write; the predictor restarts just like the DUT does.
  task automatic write_reg(input cfg_idx_e idx, input logic [EW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_MAX_NOISE: max_noise = data;
      CFG_MIN_NOISE: min_noise = data;
      CFG_WINDOW:    window    = data[WIN_W-1:0];
      CFG_SMOOTHING: smooth    = data[SMOOTH_W-1:0];
      default: ;
    endcase
    restart_floor();
  endtask

  task automatic set_config(input logic [EW-1:0] max_e, input logic [EW-1:0] min_e,
                            input int unsigned win, input int unsigned sm);
    wait_idle();
    write_reg(CFG_MAX_NOISE, max_e);
    write_reg(CFG_MIN_NOISE, min_e);
    write_reg(CFG_WINDOW, EW'(win));
    write_reg(CFG_SMOOTHING, EW'(sm));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // A noise scene: a floor with jitter, steps of 4x up or down (these move
  // the minimum enough to arm the change detector), loud bursts of 20x to
  // 200x the floor, and a few fully random frames.
  task automatic queue_scene(input int n);
    logic [EW-1:0] floor_e;
    logic [63:0]   wide;
    int            pick;
    floor_e = $urandom >> $urandom_range(28, 0);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        if (floor_e == '0) floor_e = $urandom_range(255, 1);
        else if ($urandom_range(1) == 0) floor_e = floor_e >> 2;
        else floor_e = (floor_e > 32'h3FFF_FFFF) ? '1 : floor_e << 2;
        wide = 64'(floor_e);
      end else if (pick < 18) begin
        wide = 64'(floor_e) * $urandom_range(200, 20);
      end else if (pick < 24) begin
        wide = 64'($urandom);
      end else begin
        wide = 64'(floor_e) + $urandom_range(floor_e >> 1, 0);
      end
      queue_frame((wide > 64'hFFFF_FFFF) ? '1 : wide[EW-1:0]);
    end
    random_frames += n;
  endtask

  // Idle pattern follows the progress of the random part: a busy sender with
  // a slow receiver, then the reverse, then full speed on both sides.
  task automatic run_phase(input logic [EW-1:0] max_e, input logic [EW-1:0] min_e,
                           input int unsigned win, input int unsigned sm, input int n);
    set_config(max_e, min_e, win, sm);
    if (random_frames < 150) begin
      send_idle_pct = 9;
      recv_idle_pct = 79;
    end else if (random_frames < 300) begin
      send_idle_pct = 79;
      recv_idle_pct = 9;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    queue_scene(n);
  endtask

  initial begin
    // register values after reset
    max_noise = '1;
    min_noise = EW'(1);
    window    = WINDOW_RST;
    smooth    = SMOOTH_RST;
    restart_floor();
    send_idle_pct = 9;
    recv_idle_pct = 79;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a few frames at the reset settings (zero, full scale, a loud
    // frame for the voice flag, alternating bits)
    queue_frame(32'h0000_0000);
    queue_frame(32'hFFFF_FFFF);
    queue_frame(32'h0000_0001);
    queue_frame(32'h0020_0000);
    queue_frame(32'hAAAA_AAAA);

    // Short window so the hold logic rolls over within a handful of frames.
    // A frame below the floor gets clipped before the slow tracker; a flat
    // run replaces the minimum from the candidate; the 256x step arms the
    // change detector, whose update request stops once the short window disarms it.
    set_config(32'hFFFF_FFFF, 32'h0000_0100, 2, 16'hFFFF);
    queue_frame(32'h0000_0010);
    repeat (4) queue_frame(32'h0000_0100);
    repeat (6) queue_frame(32'h0001_0000);
    queue_frame(32'h5555_5555);
    queue_frame(32'h7FFF_FFFF);
    queue_frame(32'h8000_0000);
    queue_frame(32'h0100_0000);

    // Random scenes across register settings, extremes included:
    // window of one, window of zero (minimum replaced on every hold frame,
    // detector disarmed every frame), longest window, zero and full
    // smoothing, floor at full scale, ceiling at zero.
    run_phase(32'hFFFF_FFFF, 32'h0000_0001, 3, 13107, 60);
    run_phase(32'hFFFF_FFFF, 32'h0000_0000, 1, 65535, 50);
    run_phase(32'h00FF_FFFF, 32'h0000_0100, 8, 0, 40);
    run_phase(32'hFFFF_FFFF, 32'h0000_0000, 0, 32768, 40);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5, 65535, 30);
    run_phase(32'h0000_0000, 32'h0000_0000, 2, 20000, 30);
    run_phase(32'hFFFF_FFFF, 32'h0001_0000, 1023, 65535, 60);
    repeat (3)
      run_phase($urandom, $urandom >> $urandom_range(31, 8), $urandom_range(12, 1),
                $urandom_range(65535, 0), 30);
    run_phase(32'hFFFF_FFFF, 32'h0000_0001, 100, 13107, 40);

    // drain, then give any stray result time to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("noise_floor_tracker_vad_top regression: pass");
    end else begin
      $display("noise_floor_tracker_vad_top regression: fail");
    end
    $finish;
  end

endmodule
